// File: rtl/core/soeq_pkg.sv
// Shared constants, codes and types for the size ordered eviction queue.
`default_nettype none

package soeq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 16;
    localparam int SIZE_BITS = 32;
    localparam int ACT_BITS  = 2;
    localparam int ST_BITS   = 2;
    localparam int OCC_BITS  = $clog2(DEPTH + 1);
    localparam int CNT_BITS  = $clog2(DEPTH);

    typedef enum logic [ACT_BITS-1:0] {
        ACT_ADD    = 2'd0,
        ACT_EVICT  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_MARK   = 3'd2,
        CELL_LOOK   = 3'd3,
        CELL_SWEEP  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [KEY_BITS-1:0]   key;
        logic [SIZE_BITS-1:0]  size;
    } cell_cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [SIZE_BITS-1:0]  size;
    } cell_entry_t;

    typedef struct packed {
        logic                  found;
        logic [SIZE_BITS-1:0]  size;
    } cell_res_t;

endpackage

`default_nettype wire

// File: rtl/core/soeq_if.sv
// Request and response channel interfaces of the size ordered eviction queue.
`default_nettype none

interface soeq_req_if import soeq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACT_BITS-1:0]   action;
    logic [KEY_BITS-1:0]   entry_key;
    logic [SIZE_BITS-1:0]  entry_size;

    modport source (output valid, action, entry_key, entry_size, input ready);
    modport sink   (input valid, action, entry_key, entry_size, output ready);
endinterface

interface soeq_rsp_if import soeq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KEY_BITS-1:0]   result_key;
    logic [SIZE_BITS-1:0]  result_size;
    logic [ST_BITS-1:0]    status;
    logic [OCC_BITS-1:0]   occupancy;

    modport source (output valid, result_key, result_size, status, occupancy, input ready);
    modport sink   (input valid, result_key, result_size, status, occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/core/soeq_cell.sv
// One slot of the sorted chain: holds an entry and a search result.
`default_nettype none

module soeq_cell import soeq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_cmd_t   cmd,
    input  wire logic        prev_gt,
    input  wire cell_entry_t prev_entry,
    input  wire cell_entry_t next_entry,
    input  wire cell_res_t   next_res,
    output logic             gt,
    output cell_entry_t      entry,
    output cell_res_t        res
);

    logic                 valid_reg, valid_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 found_reg, found_next;
    logic [SIZE_BITS-1:0] res_size_reg, res_size_next;
    logic                 match;

    // Local compare against the broadcast request
    assign match = valid_reg && (key_reg == cmd.key);
    assign gt    = !valid_reg || (cmd.size > size_reg);

    assign entry = '{valid: valid_reg, key: key_reg, size: size_reg};
    assign res   = '{found: found_reg, size: res_size_reg};

    // Next state of the slot
    always_comb
    begin
        valid_next    = valid_reg;
        key_next      = key_reg;
        size_next     = size_reg;
        found_next    = found_reg;
        res_size_next = res_size_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                // first slot that is empty or holds a smaller entry takes the new one,
                // the slots behind it shift down by one
                if (gt)
                begin
                    if (!prev_gt)
                    begin
                        valid_next = 1'b1;
                        key_next   = cmd.key;
                        size_next  = cmd.size;
                    end
                    else
                    begin
                        valid_next = prev_entry.valid;
                        key_next   = prev_entry.key;
                        size_next  = prev_entry.size;
                    end
                end
            end
            CELL_MARK:
            begin
                valid_next    = valid_reg && !match;
                found_next    = match;
                res_size_next = size_reg;
            end
            CELL_LOOK:
            begin
                found_next    = match;
                res_size_next = size_reg;
            end
            CELL_SWEEP:
            begin
                // holes move toward the tail one slot per cycle
                if (!valid_reg && next_entry.valid)
                begin
                    valid_next = 1'b1;
                    key_next   = next_entry.key;
                    size_next  = next_entry.size;
                end
                else if (valid_reg && !prev_entry.valid)
                begin
                    valid_next = 1'b0;
                end
                // first hit travels toward the head
                if (!found_reg)
                begin
                    found_next    = next_res.found;
                    res_size_next = next_res.size;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        size_reg     <= size_next;
        found_reg    <= found_next;
        res_size_reg <= res_size_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/size_ordered_eviction_queue.sv
// Top level: request sequencer over a chain of sorted entry cells.
//
//  channel | dir | fields                                         | accepted when
//  req     | in  | action, entry_key, entry_size                  | valid && ready
//  rsp     | out | result_key, result_size, status, occupancy     | valid && ready
//
// A request is taken only while the sequencer is idle; one is worked on at a time.
// Add, full add and empty evict: the execute step, then the finish step registers the result.
// Evict, remove and query: execute, then a sweep along the cell chain, then finish
// (holes drift to the tail, the first query hit drifts to the head, one slot a cycle).
// Reset clears the slot valid bits and the sequencer; slot payloads are not cleared.
// A result waiting on rsp stalls only the finish step of the following request.
`default_nettype none

module size_ordered_eviction_queue import soeq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    soeq_req_if.sink   req,
    soeq_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t               state_reg;
    action_t              op_action_reg;
    logic [KEY_BITS-1:0]  op_key_reg;
    logic [SIZE_BITS-1:0] op_size_reg;
    logic [KEY_BITS-1:0]  rkey_reg;
    logic [SIZE_BITS-1:0] rsize_reg;
    status_t              status_reg;
    logic [CNT_BITS-1:0]  sweep_cnt_reg;

    logic                 out_valid_reg;
    logic [KEY_BITS-1:0]  out_key_reg;
    logic [SIZE_BITS-1:0] out_size_reg;
    logic [ST_BITS-1:0]   out_status_reg;
    logic [OCC_BITS-1:0]  out_occ_reg;

    cell_cmd_t            cmd;
    logic                 gt       [DEPTH];
    logic                 prev_gt  [DEPTH];
    cell_entry_t          ent      [DEPTH];
    cell_entry_t          prev_ent [DEPTH];
    cell_entry_t          next_ent [DEPTH];
    cell_res_t            res      [DEPTH];
    cell_res_t            next_res [DEPTH];
    logic [DEPTH-1:0]     valid_vec;
    logic [OCC_BITS-1:0]  occupancy;
    logic                 full;
    logic                 empty;

    // Neighbor wiring; the head sees a full, larger neighbor, the tail an empty one
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = ent[i].valid;
            if (i == 0)
            begin
                prev_gt[i]  = 1'b0;
                prev_ent[i] = '{valid: 1'b1, key: '0, size: '0};
            end
            else
            begin
                prev_gt[i]  = gt[i-1];
                prev_ent[i] = ent[i-1];
            end
            if (i == DEPTH - 1)
            begin
                next_ent[i] = '{valid: 1'b0, key: '0, size: '0};
                next_res[i] = '{found: 1'b0, size: '0};
            end
            else
            begin
                next_ent[i] = ent[i+1];
                next_res[i] = res[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        soeq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_gt    (prev_gt[g]),
            .prev_entry (prev_ent[g]),
            .next_entry (next_ent[g]),
            .next_res   (next_res[g]),
            .gt         (gt[g]),
            .entry      (ent[g]),
            .res        (res[g])
        );
    end

    // Occupancy from the packed valid bits: position of the last valid slot
    always_comb
    begin
        occupancy = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ent[i].valid && !next_ent[i].valid)
            begin
                occupancy = occupancy | OCC_BITS'(i + 1);
            end
        end
    end

    assign full  = valid_vec[DEPTH-1];
    assign empty = !valid_vec[0];

    // Command broadcast to the chain
    always_comb
    begin
        cmd = '{op: CELL_HOLD, key: op_key_reg, size: op_size_reg};
        case (state_reg)
            S_EXEC:
            begin
                case (op_action_reg)
                    ACT_ADD:
                    begin
                        if (!full)
                        begin
                            cmd.op = CELL_INSERT;
                        end
                    end
                    ACT_EVICT:
                    begin
                        if (!empty)
                        begin
                            cmd.op  = CELL_MARK;
                            cmd.key = ent[0].key;
                        end
                    end
                    ACT_REMOVE: cmd.op = CELL_MARK;
                    ACT_QUERY:  cmd.op = CELL_LOOK;
                    default:    cmd.op = CELL_HOLD;
                endcase
            end
            S_SWEEP: cmd.op = CELL_SWEEP;
            default: cmd.op = CELL_HOLD;
        endcase
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_key  = out_key_reg;
    assign rsp.result_size = out_size_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.occupancy   = out_occ_reg;

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sweep_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
            op_action_reg  <= ACT_ADD;
            op_key_reg     <= '0;
            op_size_reg    <= '0;
            rkey_reg       <= '0;
            rsize_reg      <= '0;
            status_reg     <= ST_OK;
            out_key_reg    <= '0;
            out_size_reg   <= '0;
            out_status_reg <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            // the finish step reloads the result register itself
            if (rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_action_reg <= action_t'(req.action);
                        op_key_reg    <= req.entry_key;
                        op_size_reg   <= req.entry_size;
                        state_reg     <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    rkey_reg   <= op_key_reg;
                    rsize_reg  <= '0;
                    status_reg <= ST_OK;
                    case (op_action_reg)
                        ACT_ADD:
                        begin
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            state_reg <= S_DONE;
                        end
                        ACT_EVICT:
                        begin
                            if (empty)
                            begin
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                rkey_reg  <= ent[0].key;
                                rsize_reg <= ent[0].size;
                                state_reg <= S_SWEEP;
                            end
                        end
                        default: state_reg <= S_SWEEP;
                    endcase
                end
                S_SWEEP:
                begin
                    if (sweep_cnt_reg == CNT_BITS'(DEPTH - 1))
                    begin
                        sweep_cnt_reg <= '0;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg + CNT_BITS'(1);
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_key_reg   <= rkey_reg;
                        out_occ_reg   <= occupancy;
                        if (op_action_reg == ACT_QUERY)
                        begin
                            out_size_reg   <= res[0].found ? res[0].size : '0;
                            out_status_reg <= res[0].found ? ST_OK : ST_MISS;
                        end
                        else
                        begin
                            out_size_reg   <= rsize_reg;
                            out_status_reg <= status_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Between requests the held entries are packed at the head of the chain
    a_packed_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (valid_vec & (valid_vec + DEPTH'(1))) == '0)
        else $error("entries not packed at head while idle");

    // A dropped add is only reported with every slot taken
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg == ST_FULL) |-> full)
        else $error("full status with a free slot");

    // Sweep counter rests at zero outside the sweep
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_SWEEP |-> sweep_cnt_reg == '0)
        else $error("sweep counter running outside sweep");

    // An accepted request starts the execute step next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg == S_EXEC)
        else $error("accepted request did not start");

endmodule

`default_nettype wire
